FILE: src/mmuw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the translation table walker.
// No dependencies; compiled first.
package mmuw_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE_ZERO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE_ONE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SELECT_BITS = 2'd2;

    // Transaction codes
    localparam logic ACT_START    = 1'b0;
    localparam logic ACT_RESPONSE = 1'b1;
    localparam logic KIND_FETCH   = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    // Descriptor type field (bits 1:0)
    localparam logic [1:0] DESC_FAULT   = 2'd0;
    localparam logic [1:0] DESC_COARSE  = 2'd1;  // level 1 coarse table / level 2 large page
    localparam logic [1:0] DESC_SECTION = 2'd2;  // level 1 section / level 2 small page
    localparam logic [1:0] DESC_SMALL_X = 2'd3;  // level 2 small page, execute-never

    // Address masks
    localparam logic [31:0] MASK_TB_ALIGN    = 32'hFFFF_C000;
    localparam logic [31:0] MASK_L1_INDEX    = 32'h0000_3FFC;
    localparam logic [31:0] MASK_L2_BASE     = 32'hFFFF_FC00;
    localparam logic [31:0] MASK_L2_INDEX    = 32'h0000_03FC;
    localparam logic [31:0] MASK_LARGE_PAGE  = 32'hFFFF_0000;
    localparam logic [31:0] MASK_SMALL_PAGE  = 32'hFFFF_F000;
    localparam logic [31:0] MASK_SUPERSECT   = 32'hFF00_0000;
    localparam logic [31:0] MASK_SECTION     = 32'hFFF0_0000;
    localparam int          SUPERSECT_BIT    = 18;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_FIRST  = 2'd1,
        ST_SECOND = 2'd2
    } t_walk_stage;

    typedef struct packed {
        logic [31:0] table_base_zero;
        logic [31:0] table_base_one;
        logic [2:0]  base_select_bits;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic        fault;
        t_walk_stage next_stage;
    } t_step_res;

endpackage

FILE: src/mmuw_in_if.sv
`timescale 1ns / 1ps
// Input channel: translate requests and descriptor responses.
// Standalone; no package needed.
interface mmuw_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] virtual_address;
    logic [31:0] descriptor;

    modport source (output valid, action, virtual_address, descriptor, input ready);
    modport sink   (input valid, action, virtual_address, descriptor, output ready);
endinterface

FILE: src/mmuw_out_if.sv
`timescale 1ns / 1ps
// Output channel: descriptor fetch requests and finished translations.
// Standalone; no package needed.
interface mmuw_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] address;
    logic        fault;

    modport source (output valid, kind, address, fault, input ready);
    modport sink   (input valid, kind, address, fault, output ready);
endinterface

FILE: src/mmuw_step.sv
`timescale 1ns / 1ps
// Combinational walk step: one transaction plus current stage gives one result.
// Depends on mmuw_pkg.
module mmuw_step
    import mmuw_pkg::*;
(
    input  logic        i_action,
    input  logic [31:0] i_virtual_address,
    input  logic [31:0] i_descriptor,
    input  t_walk_stage i_stage,
    input  logic [31:0] i_saved_va,
    input  t_cfg        i_cfg,
    output t_step_res   o_res
);

    logic [31:0] top_mask;
    logic [31:0] tb_base;
    logic [31:0] l1_addr;
    logic [1:0]  desc_type;

    // First-level fetch address; top_mask is zero when N is zero
    always_comb begin
        top_mask = ~(32'hFFFF_FFFF >> i_cfg.base_select_bits);
        if ((i_virtual_address & top_mask) != 32'd0) begin
            tb_base = i_cfg.table_base_one & MASK_TB_ALIGN;
        end else begin
            tb_base = i_cfg.table_base_zero & (MASK_TB_ALIGN | (top_mask >> 18));
        end
        l1_addr = tb_base + ((i_virtual_address >> 18) & MASK_L1_INDEX);
    end

    assign desc_type = i_descriptor[1:0];

    // Result selection; anything unhandled faults back to the saved address
    always_comb begin
        o_res.kind       = KIND_DONE;
        o_res.address    = i_saved_va;
        o_res.fault      = 1'b1;
        o_res.next_stage = ST_IDLE;
        if (i_action == ACT_START) begin
            o_res.kind       = KIND_FETCH;
            o_res.address    = l1_addr;
            o_res.fault      = 1'b0;
            o_res.next_stage = ST_FIRST;
        end else if (i_stage == ST_FIRST) begin
            case (desc_type)
                DESC_COARSE: begin
                    o_res.kind       = KIND_FETCH;
                    o_res.address    = (i_descriptor & MASK_L2_BASE)
                                     + ((i_saved_va >> 10) & MASK_L2_INDEX);
                    o_res.fault      = 1'b0;
                    o_res.next_stage = ST_SECOND;
                end
                DESC_SECTION: begin
                    o_res.fault = 1'b0;
                    if (i_descriptor[SUPERSECT_BIT]) begin
                        o_res.address = (i_descriptor & MASK_SUPERSECT)
                                      | (i_saved_va & ~MASK_SUPERSECT);
                    end else begin
                        o_res.address = (i_descriptor & MASK_SECTION)
                                      | (i_saved_va & ~MASK_SECTION);
                    end
                end
                default: begin
                    o_res.fault = 1'b1;
                end
            endcase
        end else if (i_stage == ST_SECOND) begin
            case (desc_type)
                DESC_COARSE: begin
                    o_res.fault   = 1'b0;
                    o_res.address = (i_descriptor & MASK_LARGE_PAGE)
                                  | (i_saved_va & ~MASK_LARGE_PAGE);
                end
                DESC_SECTION, DESC_SMALL_X: begin
                    o_res.fault   = 1'b0;
                    o_res.address = (i_descriptor & MASK_SMALL_PAGE)
                                  | (i_saved_va & ~MASK_SMALL_PAGE);
                end
                default: begin
                    o_res.fault = 1'b1;
                end
            endcase
        end
    end

endmodule

FILE: src/mmu_translation_table_walk.sv
`timescale 1ns / 1ps
// A result is registered and valid in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; input ready stays high while the
// output register is empty or being drained in the same cycle.
// Reset (synchronous, active low) clears the table bases, base select, the
// walk stage, the saved virtual address and the output valid flag.
module mmu_translation_table_walk
    import mmuw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    mmuw_in_if.sink              i_in,
    mmuw_out_if.source           o_out
);

    t_cfg        r_cfg;
    t_walk_stage r_stage;
    logic [31:0] r_saved_va;
    logic        r_out_valid;
    logic        r_out_kind;
    logic [31:0] r_out_address;
    logic        r_out_fault;
    logic        in_acc;
    t_step_res   step_res;

    // Input accepted when the result register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TABLE_BASE_ZERO:  r_cfg.table_base_zero  <= i_cfg_data;
                CFG_TABLE_BASE_ONE:   r_cfg.table_base_one   <= i_cfg_data;
                CFG_BASE_SELECT_BITS: r_cfg.base_select_bits <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    mmuw_step u_step (
        .i_action          (i_in.action),
        .i_virtual_address (i_in.virtual_address),
        .i_descriptor      (i_in.descriptor),
        .i_stage           (r_stage),
        .i_saved_va        (r_saved_va),
        .i_cfg             (r_cfg),
        .o_res             (step_res)
    );

    // Walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage    <= ST_IDLE;
            r_saved_va <= '0;
        end else if (in_acc) begin
            r_stage <= step_res.next_stage;
            if (i_in.action == ACT_START) begin
                r_saved_va <= i_in.virtual_address;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_kind    <= step_res.kind;
            r_out_address <= step_res.address;
            r_out_fault   <= step_res.fault;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.kind    = r_out_kind;
    assign o_out.address = r_out_address;
    assign o_out.fault   = r_out_fault;

`ifndef SYNTHESIS
    // A fault only ever ends a walk
    a_fault_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fault) |-> (r_out_kind == KIND_DONE))
        else $error("fault reported on a fetch result");

    // A start always leaves the walker waiting for a first-level descriptor
    a_start_to_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.action == ACT_START) |=> (r_stage == ST_FIRST))
        else $error("start did not enter first-level stage");

    // A finished result returns the walker to idle
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && step_res.kind == KIND_DONE) |=> (r_stage == ST_IDLE))
        else $error("walk not idle after finished result");

    // Every accepted transaction produces a result next cycle
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted transaction produced no result");
`endif

endmodule

FILE: verif/mmu_translation_table_walk_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for mmu_translation_table_walk: directed table, then random walks.
// Depends on mmuw_pkg, mmuw_in_if, mmuw_out_if and the walker RTL.
module mmu_translation_table_walk_tb;
    import mmuw_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic        fault;
    } t_walk_result;

    typedef struct packed {
        logic         act;
        logic [31:0]  va;
        logic [31:0]  desc;
        logic         has_exp;   // expected result typed into the table
        t_walk_result exp;
    } t_walk_req;

    localparam int DIR_ROWS      = 27;
    localparam int PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 228;
    localparam int HOLD_CYCLES   = 250;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_data;

    mmuw_in_if  walk_req ();
    mmuw_out_if walk_rsp ();

    mmu_translation_table_walk uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (walk_req),
        .o_out      (walk_rsp)
    );

    // Predictor state and its copy of the configuration
    logic [31:0]  cfg_tb_zero;
    logic [31:0]  cfg_tb_one;
    logic [2:0]   cfg_bsel;
    t_walk_stage  walk_stage_q;
    logic [31:0]  walked_va;

    t_walk_req    pending_requests [$];
    t_walk_result expected_walk_results [$];
    int           mismatch_count;
    int           results_seen;

    // Directed stimulus; expectations typed in where they are obvious (reset config)
    t_walk_req directed_rows [DIR_ROWS] = '{
        // stray response right after reset
        '{ACT_RESPONSE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{KIND_DONE, 32'h0000_0000, 1'b1}},
        '{ACT_START,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{KIND_FETCH, 32'h0000_3FFC, 1'b0}},
        // first-level fault, type 0
        '{ACT_RESPONSE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{KIND_DONE, 32'hFFFF_FFFF, 1'b1}},
        '{ACT_START,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{KIND_FETCH, 32'h0000_0000, 1'b0}},
        // first-level fault, type 3
        '{ACT_RESPONSE, 32'hFFFF_FFFF, 32'h0000_0003, 1'b1, '{KIND_DONE, 32'h0000_0000, 1'b1}},
        // stray response after a fault
        '{ACT_RESPONSE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, '{KIND_DONE, 32'h0000_0000, 1'b1}},
        // section
        '{ACT_START,    32'h1234_5678, 32'h0000_0000, 1'b0, '0},
        '{ACT_RESPONSE, 32'h0000_0000, 32'hFFFB_FFFE, 1'b0, '0},
        // supersection
        '{ACT_START,    32'h89AB_CDEF, 32'h0000_0000, 1'b0, '0},
        '{ACT_RESPONSE, 32'h0000_0000, 32'hABCD_E002, 1'b0, '0},
        // coarse table then large page, all ones
        '{ACT_START,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{KIND_FETCH, 32'h0000_3FFC, 1'b0}},
        '{ACT_RESPONSE, 32'h0000_0000, 32'hFFFF_FFFD, 1'b0, '0},
        '{ACT_RESPONSE, 32'h0000_0000, 32'hFFFF_FFFD, 1'b1, '{KIND_DONE, 32'hFFFF_FFFF, 1'b0}},
        // coarse table then small page, all zeros
        '{ACT_START,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{KIND_FETCH, 32'h0000_0000, 1'b0}},
        '{ACT_RESPONSE, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{KIND_FETCH, 32'h0000_0000, 1'b0}},
        '{ACT_RESPONSE, 32'hFFFF_FFFF, 32'h0000_0002, 1'b1, '{KIND_DONE, 32'h0000_0000, 1'b0}},
        // small page, execute-never encoding
        '{ACT_START,    32'hDEAD_BEEF, 32'h0000_0000, 1'b0, '0},
        '{ACT_RESPONSE, 32'h0000_0000, 32'h5555_5555, 1'b0, '0},
        '{ACT_RESPONSE, 32'h0000_0000, 32'hAAAA_AAAB, 1'b0, '0},
        // second-level fault
        '{ACT_START,    32'h0F0F_0F0F, 32'h0000_0000, 1'b0, '0},
        '{ACT_RESPONSE, 32'h0000_0000, 32'h1234_5401, 1'b0, '0},
        '{ACT_RESPONSE, 32'h0000_0000, 32'hFFFF_FFFC, 1'b1, '{KIND_DONE, 32'h0F0F_0F0F, 1'b1}},
        // restart while waiting on first level, then on second level
        '{ACT_START,    32'h4000_0000, 32'h0000_0000, 1'b0, '0},
        '{ACT_START,    32'h8000_0000, 32'h0000_0000, 1'b0, '0},
        '{ACT_RESPONSE, 32'h0000_0000, 32'hCAFE_0001, 1'b0, '0},
        '{ACT_START,    32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{ACT_RESPONSE, 32'h0000_0000, 32'h0000_0002, 1'b0, '0}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // First-level descriptor address for a virtual address
    function automatic logic [31:0] l1_desc_addr(input logic [31:0] va);
        logic [31:0] top_mask;
        logic [31:0] base;
        top_mask = ~(32'hFFFF_FFFF >> cfg_bsel);
        if ((va & top_mask) != 32'h0)
            base = cfg_tb_one & MASK_TB_ALIGN;
        else
            base = cfg_tb_zero & (MASK_TB_ALIGN | (top_mask >> 18));
        return base + ((va >> 18) & MASK_L1_INDEX);
    endfunction

    // Advance the walk for one accepted transaction and return its result
    function automatic t_walk_result predict_walk_step(input t_walk_req rq);
        t_walk_result r;
        r.kind    = KIND_DONE;
        r.address = walked_va;
        r.fault   = 1'b1;
        if (rq.act == ACT_START) begin
            walked_va    = rq.va;
            walk_stage_q = ST_FIRST;
            r.kind       = KIND_FETCH;
            r.address    = l1_desc_addr(rq.va);
            r.fault      = 1'b0;
        end else begin
            case (walk_stage_q)
                ST_FIRST: begin
                    walk_stage_q = ST_IDLE;
                    case (rq.desc[1:0])
                        DESC_COARSE: begin
                            walk_stage_q = ST_SECOND;
                            r.kind    = KIND_FETCH;
                            r.address = (rq.desc & MASK_L2_BASE)
                                      + ((walked_va >> 10) & MASK_L2_INDEX);
                            r.fault   = 1'b0;
                        end
                        DESC_SECTION: begin
                            r.fault = 1'b0;
                            if (rq.desc[SUPERSECT_BIT])
                                r.address = (rq.desc & MASK_SUPERSECT)
                                          | (walked_va & ~MASK_SUPERSECT);
                            else
                                r.address = (rq.desc & MASK_SECTION)
                                          | (walked_va & ~MASK_SECTION);
                        end
                        default: ;
                    endcase
                end
                ST_SECOND: begin
                    walk_stage_q = ST_IDLE;
                    case (rq.desc[1:0])
                        DESC_COARSE: begin
                            r.fault   = 1'b0;
                            r.address = (rq.desc & MASK_LARGE_PAGE)
                                      | (walked_va & ~MASK_LARGE_PAGE);
                        end
                        DESC_SECTION, DESC_SMALL_X: begin
                            r.fault   = 1'b0;
                            r.address = (rq.desc & MASK_SMALL_PAGE)
                                      | (walked_va & ~MASK_SMALL_PAGE);
                        end
                        default: ;
                    endcase
                end
                default: walk_stage_q = ST_IDLE;
            endcase
        end
        return r;
    endfunction

    function automatic t_walk_req mk_req(input logic act, input logic [31:0] va,
                                         input logic [31:0] desc);
        t_walk_req rq;
        rq         = '0;
        rq.act     = act;
        rq.va      = va;
        rq.desc    = desc;
        return rq;
    endfunction

    // Descriptor with random content and a chosen type
    function automatic logic [31:0] rand_desc(input logic [1:0] dtype);
        logic [31:0] d;
        d      = $urandom;
        d[1:0] = dtype;
        return d;
    endfunction

    // Random walks: mostly well-formed, some cut short, some noise
    task automatic queue_walks(input int count);
        int          added;
        int          pick;
        logic [31:0] va;
        logic [31:0] d;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                pending_requests.push_back(mk_req(1'($urandom_range(0, 1)), $urandom,
                                                  $urandom));
                added++;
            end else begin
                va = $urandom;
                if ($urandom_range(0, 3) == 0)
                    va = va >> $urandom_range(1, 10);
                pending_requests.push_back(mk_req(ACT_START, va, $urandom));
                added++;
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    pending_requests.push_back(mk_req(ACT_RESPONSE, $urandom,
                                                      rand_desc(DESC_COARSE)));
                    added++;
                    // second level, sometimes abandoned
                    if ($urandom_range(0, 9) != 0) begin
                        pending_requests.push_back(mk_req(ACT_RESPONSE, $urandom,
                                                          rand_desc(2'($urandom_range(0, 3)))));
                        added++;
                    end
                end else if (pick < 75) begin
                    d = rand_desc(DESC_SECTION);
                    d[SUPERSECT_BIT] = (pick < 60);
                    pending_requests.push_back(mk_req(ACT_RESPONSE, $urandom, d));
                    added++;
                end else if (pick < 85) begin
                    d = rand_desc($urandom_range(0, 1) ? DESC_FAULT : DESC_SMALL_X);
                    pending_requests.push_back(mk_req(ACT_RESPONSE, $urandom, d));
                    added++;
                end
                // otherwise the walk is left open and the next start drops it
                if ($urandom_range(0, 19) == 0) begin
                    pending_requests.push_back(mk_req(ACT_RESPONSE, $urandom, $urandom));
                    added++;
                end
            end
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_TABLE_BASE_ZERO:  cfg_tb_zero = data;
            CFG_TABLE_BASE_ONE:   cfg_tb_one  = data;
            CFG_BASE_SELECT_BITS: cfg_bsel    = data[2:0];
            default: ;
        endcase
    endtask

    // Block until every queued transaction went through and every result came back
    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_walk_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Request side: bursts with random gaps, prediction on acceptance
    initial begin
        int        burst_left;
        int        gap_left;
        t_walk_req rq;
        burst_left = 1;
        gap_left   = 0;
        walk_req.valid           <= 1'b0;
        walk_req.action          <= ACT_START;
        walk_req.virtual_address <= 32'h0;
        walk_req.descriptor      <= 32'h0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (walk_req.valid && walk_req.ready) begin
                rq = pending_requests.pop_front();
                if (rq.has_exp) begin
                    void'(predict_walk_step(rq));
                    expected_walk_results.push_back(rq.exp);
                end else begin
                    expected_walk_results.push_back(predict_walk_step(rq));
                end
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (walk_req.valid && !walk_req.ready) begin
                // hold the offered transaction
            end else if (gap_left > 0) begin
                walk_req.valid <= 1'b0;
                gap_left--;
            end else if (pending_requests.size() != 0) begin
                walk_req.valid           <= 1'b1;
                walk_req.action          <= pending_requests[0].act;
                walk_req.virtual_address <= pending_requests[0].va;
                walk_req.descriptor      <= pending_requests[0].desc;
            end else begin
                walk_req.valid <= 1'b0;
            end
        end
    end

    // Result side: compare, then stall on a pattern of its own with two long hold-offs
    initial begin
        int           mode;
        int           mode_left;
        int           hold_left;
        logic [31:0]  pattern;
        t_walk_result ex;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        pattern   = 32'h0;
        walk_rsp.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (walk_rsp.valid && walk_rsp.ready) begin
                results_seen++;
                if (expected_walk_results.size() == 0) begin
                    $error("unexpected result transaction: kind %0d address %h fault %0d",
                           walk_rsp.kind, walk_rsp.address, walk_rsp.fault);
                    mismatch_count++;
                end else begin
                    ex = expected_walk_results.pop_front();
                    if (walk_rsp.kind !== ex.kind) begin
                        $error("kind: expected %0d, got %0d", ex.kind, walk_rsp.kind);
                        mismatch_count++;
                    end
                    if (walk_rsp.address !== ex.address) begin
                        $error("address: expected %h, got %h", ex.address, walk_rsp.address);
                        mismatch_count++;
                    end
                    if (walk_rsp.fault !== ex.fault) begin
                        $error("fault: expected %0d, got %0d", ex.fault, walk_rsp.fault);
                        mismatch_count++;
                    end
                end
                if (results_seen == 400 || results_seen == 1300)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                walk_rsp.ready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left <= 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                    pattern   = $urandom;
                end
                mode_left--;
                case (mode)
                    0: walk_rsp.ready <= 1'b1;
                    1: walk_rsp.ready <= 1'($urandom_range(0, 1));
                    default: begin
                        walk_rsp.ready <= pattern[0];
                        pattern = {pattern[0], pattern[31:1]};
                    end
                endcase
            end
        end
    end

    // Main sequence: reset, directed table, then one random phase per configuration
    initial begin
        cfg_tb_zero    = 32'h0;
        cfg_tb_one     = 32'h0;
        cfg_bsel       = 3'd0;
        walk_stage_q   = ST_IDLE;
        walked_va      = 32'h0;
        mismatch_count = 0;
        results_seen   = 0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_TABLE_BASE_ZERO;
        i_cfg_data <= 32'h0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            pending_requests.push_back(directed_rows[i]);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                write_cfg(CFG_TABLE_BASE_ZERO, 32'h0);
                write_cfg(CFG_TABLE_BASE_ONE, 32'h0);
                write_cfg(CFG_BASE_SELECT_BITS, 32'h0);
            end else if (ph == PHASES - 1) begin
                write_cfg(CFG_TABLE_BASE_ZERO, 32'hFFFF_FFFF);
                write_cfg(CFG_TABLE_BASE_ONE, 32'hFFFF_FFFF);
                write_cfg(CFG_BASE_SELECT_BITS, 32'hFFFF_FFFF);
            end else begin
                write_cfg(CFG_TABLE_BASE_ZERO, $urandom);
                write_cfg(CFG_TABLE_BASE_ONE, $urandom);
                write_cfg(CFG_BASE_SELECT_BITS, 32'(ph));
            end
            queue_walks(ITEMS_PER_PHASE);
            wait_drained();
        end

        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_walk_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
